// ===== sv/poi_pkg.sv =====
// Shared types, constants and the arctangent table of the planar odometry integrator.
package poi_pkg;

   localparam int ANGLE_BITS_DEF     = 32;
   localparam int TRIG_FRAC_BITS_DEF = 15;

   localparam int CORDIC_ITERS = 24;
   localparam int CORDIC_W     = 34;
   localparam int CNT_W        = 5;
   localparam longint CORDIC_X0 = 64'd652032874;

   // round(2^64 / (2 pi 1e9)) split into high and low 16-bit halves
   localparam int TURN_KH = 44798;
   localparam int TURN_KL = 8775;

   localparam logic [19:0] MAX_ELAPSED = 20'd1000000;

   typedef logic signed [15:0] vel_type;
   typedef logic [19:0]        elapsed_type;
   typedef logic signed [63:0] pos_type;
   typedef logic [31:0]        heading_type;

   // atan(2^-i) as a 32-bit binary angle
   function automatic logic [31:0] atan_angle(input logic [CNT_W-1:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

// ===== sv/poi_cordic.sv =====
// Iterative rotation-mode CORDIC giving rounded, clamped cosine and sine of a binary angle.
module poi_cordic #(
   parameter int TRIG_FRAC_BITS = poi_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [31:0]                      angle,
   output logic                             done,
   output logic signed [TRIG_FRAC_BITS:0]   cos_out,
   output logic signed [TRIG_FRAC_BITS:0]   sin_out
);
   import poi_pkg::*;

   localparam int CW = TRIG_FRAC_BITS + 1;
   localparam int XW = CORDIC_W;
   localparam int TS = 30 - TRIG_FRAC_BITS;
   localparam logic signed [XW-1:0] RND_H   = XW'(1) <<< (TS - 1);
   localparam logic signed [XW-1:0] LIM     = (XW'(1) <<< TRIG_FRAC_BITS) - XW'(1);
   localparam logic signed [XW-1:0] QUARTER = XW'(64'd1073741824);
   localparam logic signed [XW-1:0] HALF    = XW'(64'd2147483648);

   typedef enum logic [1:0] {C_IDLE, C_ITER, C_FIN} cstate_type;

   cstate_type              state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [XW-1:0]    x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                    flip_ff, flip_in;
   logic                    done_ff, done_in;
   logic signed [CW-1:0]    cos_ff, cos_in, sin_ff, sin_in;

   logic signed [XW-1:0]    z0, x_sh, y_sh, atan_v, xf, yf;

   function automatic logic signed [CW-1:0] trig_round(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] r;
      r = (v + (v[XW-1] ? RND_H - XW'(1) : RND_H)) >>> TS;
      if (r > LIM) begin
         r = LIM;
      end else if (r < -LIM) begin
         r = -LIM;
      end
      return CW'(r);
   endfunction

   always_comb begin
      z0     = XW'(signed'(angle));
      x_sh   = x_ff >>> cnt_ff;
      y_sh   = y_ff >>> cnt_ff;
      atan_v = XW'(atan_angle(cnt_ff));
      xf     = flip_ff ? -x_ff : x_ff;
      yf     = flip_ff ? -y_ff : y_ff;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      flip_in  = flip_ff;
      done_in  = 1'b0;
      cos_in   = cos_ff;
      sin_in   = sin_ff;

      case (state_ff)
         C_IDLE: begin
            if (start) begin
               // fold into [-pi/2, pi/2]; results negated at the end
               x_in    = XW'(CORDIC_X0);
               y_in    = '0;
               cnt_in  = '0;
               flip_in = 1'b0;
               z_in    = z0;
               if (z0 > QUARTER) begin
                  z_in    = z0 - HALF;
                  flip_in = 1'b1;
               end else if (z0 < -QUARTER) begin
                  z_in    = z0 + HALF;
                  flip_in = 1'b1;
               end
               state_in = C_ITER;
            end
         end
         C_ITER: begin
            if (!z_ff[XW-1]) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_v;
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_v;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CORDIC_ITERS - 1)) begin
               state_in = C_FIN;
            end
         end
         C_FIN: begin
            cos_in   = trig_round(xf);
            sin_in   = trig_round(yf);
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ===== sv/poi_mul.sv =====
// Shared signed multiplier with a registered product.
module poi_mul #(
   parameter int AW = 36,
   parameter int BW = 21
) (
   input  logic                    clock,
   input  logic signed [AW-1:0]    op_a,
   input  logic signed [BW-1:0]    op_b,
   output logic signed [AW+BW-1:0] prod
);
   logic signed [AW+BW-1:0] prod_ff, prod_in;

   assign prod_in = (AW + BW)'(op_a) * (AW + BW)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== sv/planar_odometry_integrator_unit.sv =====
// Planar odometry integrator: one report is worked on at a time, and a new report is taken only
// after the last one has been committed. The held heading goes through a 24-step CORDIC: 24
// iterations, a rounding step and a step to hand the sine and cosine over. One shared
// multiplier then runs nine products back to back: the velocity rotation, the elapsed-time
// scaling and the heading-advance coefficient. A final step commits the saturating x/y
// accumulators and the wrapping heading. That step waits while an earlier result is still
// stalled. req_stall is high from the transfer until the commit. A result waits in its own
// output registers, so the next report may be taken before it is transferred.
module planar_odometry_integrator_unit #(
   parameter int ANGLE_BITS     = poi_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_FRAC_BITS = poi_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  poi_pkg::vel_type      req_vel_x,
   input  poi_pkg::vel_type      req_vel_y,
   input  poi_pkg::vel_type      req_yaw_rate,
   input  poi_pkg::elapsed_type  req_elapsed_us,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output poi_pkg::pos_type      rsp_pos_x,
   output poi_pkg::pos_type      rsp_pos_y,
   output poi_pkg::heading_type  rsp_heading
);
   import poi_pkg::*;

   localparam int F    = TRIG_FRAC_BITS;
   localparam int AB   = ANGLE_BITS;
   localparam int CW   = F + 1;
   localparam int EW   = F + 17;
   localparam int MGW  = 35;
   localparam int MAW  = (EW > MGW + 1) ? EW : MGW + 1;
   localparam int MBW  = (CW > 21) ? CW : 21;
   localparam int PW   = MAW + MBW;
   localparam int HSW  = 52;
   localparam logic signed [PW-1:0] RND_H = PW'(1) <<< (F - 1);
   localparam logic [HSW-1:0] HRND = HSW'(1) << (47 - AB);
   localparam logic signed [63:0] POS_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] POS_MIN = {1'b1, {63{1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE, S_TRIG, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_MUL4,
      S_MUL5, S_MUL6, S_MUL7, S_MUL8, S_MUL9, S_ACC
   } state_type;

   state_type               state_ff, state_in;
   logic signed [15:0]      vx_ff, vx_in, vy_ff, vy_in, wz_ff, wz_in;
   logic [19:0]             dt_ff, dt_in;
   logic signed [EW-1:0]    ex_ff, ex_in, ey_ff, ey_in;
   logic                    wneg_ff, wneg_in;
   logic [MGW-1:0]          mag_ff, mag_in;
   logic signed [PW-1:0]    dxw_ff, dxw_in, dyw_ff, dyw_in;
   logic [HSW-1:0]          ha_ff, ha_in, hsum_ff, hsum_in;
   logic signed [63:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic signed [63:0]      acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [AB-1:0]           acc_heading_ff, acc_heading_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [63:0]      rsp_pos_x_ff, rsp_pos_x_in, rsp_pos_y_ff, rsp_pos_y_in;
   logic [31:0]             rsp_heading_ff, rsp_heading_in;

   logic                    accept, out_free, rsp_xfer;
   logic [19:0]             el_clamped;
   logic [31:0]             cor_angle;
   logic                    cor_done;
   logic signed [CW-1:0]    cos_v, sin_v;
   logic signed [MAW-1:0]   mul_a;
   logic signed [MBW-1:0]   mul_b;
   logic signed [PW-1:0]    prod;
   logic signed [MBW-1:0]   dt_op;
   logic [HSW-1:0]          q_full;
   logic [AB-1:0]           q_ang, dh;

   function automatic logic signed [63:0] rnd_disp(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      r = (v + (v[PW-1] ? RND_H - PW'(1) : RND_H)) >>> F;
      return 64'(r);
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         return s[64] ? POS_MIN : POS_MAX;
      end
      return s[63:0];
   endfunction

   poi_cordic #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   poi_mul #(
      .AW(MAW),
      .BW(MBW)
   ) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_xfer   = rsp_valid_ff && !rsp_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign el_clamped = (req_elapsed_us > MAX_ELAPSED) ? MAX_ELAPSED : req_elapsed_us;
   assign cor_angle  = 32'(acc_heading_ff) << (32 - AB);
   assign dt_op      = MBW'(signed'({1'b0, dt_ff}));

   // heading advance magnitude, then signed and wrapped to the angle width
   assign q_full = (hsum_ff + HRND) >> (48 - AB);
   assign q_ang  = AB'(q_full);
   assign dh     = wneg_ff ? -q_ang : q_ang;

   always_comb begin
      state_in       = state_ff;
      vx_in          = vx_ff;
      vy_in          = vy_ff;
      wz_in          = wz_ff;
      dt_in          = dt_ff;
      ex_in          = ex_ff;
      ey_in          = ey_ff;
      wneg_in        = wneg_ff;
      mag_in         = mag_ff;
      dxw_in         = dxw_ff;
      dyw_in         = dyw_ff;
      ha_in          = ha_ff;
      hsum_in        = hsum_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      acc_x_in       = acc_x_ff;
      acc_y_in       = acc_y_ff;
      acc_heading_in = acc_heading_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      rsp_heading_in = rsp_heading_ff;
      rsp_valid_in   = rsp_xfer ? 1'b0 : rsp_valid_ff;
      mul_a          = '0;
      mul_b          = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               vx_in    = req_vel_x;
               vy_in    = req_vel_y;
               wz_in    = req_yaw_rate;
               dt_in    = el_clamped;
               state_in = S_TRIG;
            end
         end
         S_TRIG: begin
            if (cor_done) begin
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            mul_a    = MAW'(vx_ff);
            mul_b    = MBW'(cos_v);
            state_in = S_MUL1;
         end
         S_MUL1: begin
            mul_a    = MAW'(vy_ff);
            mul_b    = MBW'(sin_v);
            ex_in    = EW'(prod);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            mul_a    = MAW'(vx_ff);
            mul_b    = MBW'(sin_v);
            ex_in    = ex_ff - EW'(prod);
            state_in = S_MUL3;
         end
         S_MUL3: begin
            mul_a    = MAW'(vy_ff);
            mul_b    = MBW'(cos_v);
            ey_in    = EW'(prod);
            state_in = S_MUL4;
         end
         S_MUL4: begin
            mul_a    = MAW'(wz_ff);
            mul_b    = dt_op;
            ey_in    = ey_ff + EW'(prod);
            state_in = S_MUL5;
         end
         S_MUL5: begin
            mul_a    = MAW'(ex_ff);
            mul_b    = dt_op;
            wneg_in  = prod[PW-1];
            mag_in   = MGW'(prod[PW-1] ? -prod : prod);
            state_in = S_MUL6;
         end
         S_MUL6: begin
            mul_a    = MAW'(ey_ff);
            mul_b    = dt_op;
            dxw_in   = prod;
            state_in = S_MUL7;
         end
         S_MUL7: begin
            mul_a    = MAW'(signed'({1'b0, mag_ff}));
            mul_b    = MBW'(TURN_KH);
            dyw_in   = prod;
            state_in = S_MUL8;
         end
         S_MUL8: begin
            mul_a    = MAW'(signed'({1'b0, mag_ff}));
            mul_b    = MBW'(TURN_KL);
            ha_in    = prod[HSW-1:0];
            dx_in    = rnd_disp(dxw_ff);
            state_in = S_MUL9;
         end
         S_MUL9: begin
            hsum_in  = ha_ff + (prod[HSW-1:0] >> 16);
            dy_in    = rnd_disp(dyw_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            // commit only once the output registers are free
            if (out_free) begin
               acc_x_in       = sat_add(acc_x_ff, dx_ff);
               acc_y_in       = sat_add(acc_y_ff, dy_ff);
               acc_heading_in = acc_heading_ff + dh;
               rsp_pos_x_in   = acc_x_in;
               rsp_pos_y_in   = acc_y_in;
               rsp_heading_in = 32'(acc_heading_in);
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         acc_x_ff       <= '0;
         acc_y_ff       <= '0;
         acc_heading_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         acc_x_ff       <= acc_x_in;
         acc_y_ff       <= acc_y_in;
         acc_heading_ff <= acc_heading_in;
      end
      vx_ff          <= vx_in;
      vy_ff          <= vy_in;
      wz_ff          <= wz_in;
      dt_ff          <= dt_in;
      ex_ff          <= ex_in;
      ey_ff          <= ey_in;
      wneg_ff        <= wneg_in;
      mag_ff         <= mag_in;
      dxw_ff         <= dxw_in;
      dyw_ff         <= dyw_in;
      ha_ff          <= ha_in;
      hsum_ff        <= hsum_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_heading_ff <= rsp_heading_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;
   assign rsp_heading = rsp_heading_ff;

`ifndef SYNTHESIS
   a_cordic_done_in_trig: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == S_TRIG))
      else $error("CORDIC finished outside the wait state");

   a_rsp_from_acc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_ACC))
      else $error("result raised without an accumulate step");

   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(state_ff != S_ACC)) |-> ($stable(acc_x_ff) && $stable(acc_y_ff)))
      else $error("position accumulator moved outside the accumulate step");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((64'(rsp_heading) >> AB) == 64'd0))
      else $error("heading has bits above the angle width");
`endif

endmodule
